FILE: rtl/max_frequency_stack_macros.svh
// Assertion macros for the frequency stack
`ifndef MAX_FREQUENCY_STACK_MACROS_SVH
`define MAX_FREQUENCY_STACK_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MFS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MFS_ASSERT_ALWAYS(lbl, expr, msg)
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/mfs_pkg.sv
package mfs_pkg;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic cmp_en;
		logic cmp_pop;
		logic wr;
		logic shift;
	} cell_ctl_t;

endpackage

FILE: rtl/max_frequency_stack.sv
// Maximum-frequency stack.
// Input stream: s_axis_tuser[0] is the mode (0 push, 1 pop), s_axis_tdata
// carries the value to push. Output stream: one result beat per input beat,
// m_axis_tdata is the popped value (zero on push or refused pop) and
// m_axis_tuser is the status (0 ok, 1 pop while empty, 2 push while full).
// Entries live in a row of DEPTH cells in push order. In the accept cycle
// every cell compares itself against the beat (value for a push, level
// against the top level for a pop) and registers a match bit. In the search
// state a prefix search finds the newest match; a push writes the cell at
// the fill point, a pop pulls every cell above the hit one place down.
// A new beat is accepted only once the last one has left the search state;
// the compare-then-search over the cell row sets this.
// The result register lets the next beat in while the last result waits.
// If the receiver stalls, the second item waits in the search cycle and
// input acceptance stops until the result register drains.
// Reset empties the stack at once: no clearing pass.
`include "max_frequency_stack_macros.svh"

module max_frequency_stack #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] push_value
	input  logic        s_axis_tuser,  // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] popped_value
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
	import mfs_pkg::*;

	localparam int CB = $clog2(DEPTH + 1);

	state_t                state_q;
	logic                  mode_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [CB-1:0]         count_q;
	logic [CB-1:0]         top_q;
	logic                  m_valid_q;
	logic [31:0]           m_value_q;
	logic [1:0]            m_status_q;

	logic                  accept;
	logic                  out_free;
	logic                  commit;
	logic                  push_ok;
	logic                  pop_ok;
	logic [VALUE_BITS-1:0] key;
	logic [CB-1:0]         new_lvl;

	logic [DEPTH-1:0]      match;
	logic [VALUE_BITS-1:0] values [DEPTH];
	logic [CB-1:0]         levels [DEPTH];
	logic [DEPTH-1:0]      valids;
	logic                  found;
	logic                  others;
	logic [VALUE_BITS-1:0] sel_value;
	logic [CB-1:0]         sel_level;
	logic [DEPTH-1:0]      shift_mask;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept   = s_axis_tvalid & s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign commit   = (state_q == ST_EXEC) && out_free;
	assign push_ok  = commit && (mode_q == MODE_PUSH) && (count_q != CB'(DEPTH));
	assign pop_ok   = commit && (mode_q == MODE_POP) && (count_q != '0);
	assign key      = (state_q == ST_IDLE) ? VALUE_BITS'(s_axis_tdata) : key_q;
	assign new_lvl  = found ? sel_level + CB'(1) : CB'(1);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t             ctl;
		logic                  nb_valid;
		logic [VALUE_BITS-1:0] nb_value;
		logic [CB-1:0]         nb_level;

		assign ctl.cmp_en  = accept;
		assign ctl.cmp_pop = s_axis_tuser;
		assign ctl.wr      = push_ok && (count_q == CB'(i));
		assign ctl.shift   = pop_ok && shift_mask[i];

		if (i == DEPTH - 1) begin : g_end
			assign nb_valid = 1'b0;
			assign nb_value = '0;
			assign nb_level = '0;
		end else begin : g_mid
			assign nb_valid = valids[i+1];
			assign nb_value = values[i+1];
			assign nb_level = levels[i+1];
		end

		mfs_cell #(
			.VALUE_BITS(VALUE_BITS),
			.LEVEL_BITS(CB)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key      (key),
			.cmp_level(top_q),
			.wr_level (new_lvl),
			.nb_valid (nb_valid),
			.nb_value (nb_value),
			.nb_level (nb_level),
			.valid    (valids[i]),
			.value    (values[i]),
			.level    (levels[i]),
			.match    (match[i])
		);
	end

	mfs_select #(
		.DEPTH     (DEPTH),
		.VALUE_BITS(VALUE_BITS),
		.LEVEL_BITS(CB)
	) u_select (
		.match     (match),
		.values    (values),
		.levels    (levels),
		.found     (found),
		.others    (others),
		.sel_value (sel_value),
		.sel_level (sel_level),
		.shift_mask(shift_mask)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			top_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (push_ok) begin
				count_q <= count_q + CB'(1);
				if (new_lvl > top_q) begin
					top_q <= new_lvl;
				end
			end
			if (pop_ok) begin
				count_q <= count_q - CB'(1);
				if (!others && top_q != '0) begin
					top_q <= top_q - CB'(1);
				end
			end
			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_axis_tuser;
			key_q  <= VALUE_BITS'(s_axis_tdata);
		end
		if (commit) begin
			m_value_q  <= pop_ok ? 32'(sel_value) : 32'd0;
			if (mode_q == MODE_PUSH) begin
				m_status_q <= push_ok ? STATUS_OK : STATUS_FULL;
			end else begin
				m_status_q <= pop_ok ? STATUS_OK : STATUS_EMPTY;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_value_q;
	assign m_axis_tuser  = m_status_q;

	`MFS_ASSERT_ALWAYS(a_count_range, count_q <= CB'(DEPTH), "fill count beyond depth")
	`MFS_ASSERT_ALWAYS(a_top_nonzero, (count_q == '0) == (top_q == '0), "top level out of step with fill")
	`MFS_ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC && !s_axis_tready, "accepted beat not in search")
	`MFS_ASSERT_NEXT(a_pop_hit, pop_ok, $past(found), "pop found no entry at top level")

endmodule

FILE: rtl/mfs_cell.sv
module mfs_cell #(
	parameter int VALUE_BITS = 32,
	parameter int LEVEL_BITS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mfs_pkg::cell_ctl_t    ctl,
	input  logic [VALUE_BITS-1:0] key,
	input  logic [LEVEL_BITS-1:0] cmp_level,
	input  logic [LEVEL_BITS-1:0] wr_level,
	input  logic                  nb_valid,
	input  logic [VALUE_BITS-1:0] nb_value,
	input  logic [LEVEL_BITS-1:0] nb_level,
	output logic                  valid,
	output logic [VALUE_BITS-1:0] value,
	output logic [LEVEL_BITS-1:0] level,
	output logic                  match
);
	import mfs_pkg::*;

	logic                  valid_q;
	logic                  match_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [LEVEL_BITS-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp_en) begin
				match_q <= valid_q & (ctl.cmp_pop ? (level_q == cmp_level) : (value_q == key));
			end
			if (ctl.shift) begin
				valid_q <= nb_valid;
			end else if (ctl.wr) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= nb_value;
			level_q <= nb_level;
		end else if (ctl.wr) begin
			value_q <= key;
			level_q <= wr_level;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign level = level_q;
	assign match = match_q;

endmodule

FILE: rtl/mfs_select.sv
module mfs_select #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32,
	parameter int LEVEL_BITS = 7
) (
	input  logic [DEPTH-1:0]      match,
	input  logic [VALUE_BITS-1:0] values [DEPTH],
	input  logic [LEVEL_BITS-1:0] levels [DEPTH],
	output logic                  found,
	output logic                  others,
	output logic [VALUE_BITS-1:0] sel_value,
	output logic [LEVEL_BITS-1:0] sel_level,
	output logic [DEPTH-1:0]      shift_mask
);
	import mfs_pkg::*;

	logic [DEPTH-1:0] sfx;
	logic [DEPTH-1:0] above;
	logic [DEPTH-1:0] last_oh;

	// sfx[i]: some match at index i or higher
	always_comb begin
		sfx = match;
		for (int s = 1; s < DEPTH; s = s * 2) begin
			sfx = sfx | (sfx >> s);
		end
		above   = sfx >> 1;
		last_oh = match & ~above;
		found   = |match;
		others  = |(match & ~last_oh);
		shift_mask = ~above;
		sel_value = '0;
		sel_level = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (last_oh[i]) begin
				sel_value = sel_value | values[i];
				sel_level = sel_level | levels[i];
			end
		end
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import mfs_pkg::*;

	localparam int DEPTH          = 64;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} outcome_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = MODE_PUSH;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	logic [31:0] stack_values [DEPTH];
	logic [6:0]  stack_levels [DEPTH];
	int          stack_fill    = 0;
	int          stack_top     = 0;
	outcome_t    owed_results [$];

	int mismatches  = 0;
	int idle_cycles = 0;
	int stall_left  = 0;
	bit steady      = 1'b0;

	max_frequency_stack #(
		.DEPTH(DEPTH),
		.VALUE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Updates the frequency stack image and returns the result owed for one beat.
	function automatic outcome_t apply_beat(logic mode, logic [31:0] value);
		outcome_t res;
		int copies;
		int hit;
		int i;
		bit still_held;
		res.value  = '0;
		res.status = STATUS_OK;
		if (mode == MODE_PUSH) begin
			if (stack_fill == DEPTH) begin
				res.status = STATUS_FULL;
				return res;
			end
			copies = 0;
			for (i = 0; i < stack_fill; i++)
				if (stack_values[i] == value) copies++;
			stack_values[stack_fill] = value;
			stack_levels[stack_fill] = 7'(copies + 1);
			stack_fill++;
			if (copies + 1 > stack_top) stack_top = copies + 1;
			return res;
		end
		if (stack_fill == 0) begin
			res.status = STATUS_EMPTY;
			return res;
		end
		hit = stack_fill - 1;
		for (i = stack_fill - 1; i >= 0; i--) begin
			if (stack_levels[i] == 7'(stack_top)) begin
				hit = i;
				break;
			end
		end
		res.value = stack_values[hit];
		for (i = hit; i + 1 < stack_fill; i++) begin
			stack_values[i] = stack_values[i + 1];
			stack_levels[i] = stack_levels[i + 1];
		end
		stack_fill--;
		still_held = 1'b0;
		for (i = 0; i < stack_fill; i++)
			if (stack_levels[i] == 7'(stack_top)) still_held = 1'b1;
		if (!still_held && stack_top > 0) stack_top--;
		return res;
	endfunction

	always @(posedge clk) begin : track_beats
		outcome_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat: value %h status %0d",
							m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					if (m_axis_tdata !== want.value || m_axis_tuser !== want.status) begin
						if (mismatches < 10)
							$display("mismatch: expected value %h status %0d, got value %h status %0d",
								want.value, want.status, m_axis_tdata, m_axis_tuser);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				owed_results.push_back(apply_beat(s_axis_tuser, s_axis_tdata));
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) stall_left--;
		else if ((m_axis_tvalid && m_axis_tready) || $urandom_range(0, 7) == 0)
			stall_left = pick_gap();
		m_axis_tready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_beat(input logic mode, input logic [31:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic push_beat(input logic [31:0] value);
		send_beat(MODE_PUSH, value);
	endtask

	task automatic pop_beat();
		send_beat(MODE_POP, $urandom);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_pop();
		pop_beat();
		pop_beat();
	endtask

	task automatic test_value_extremes();
		push_beat(32'h0000_0000);
		push_beat(32'hFFFF_FFFF);
		push_beat(32'hAAAA_AAAA);
		push_beat(32'h5555_5555);
		repeat (5) pop_beat();
	endtask

	task automatic test_frequency_order();
		push_beat(32'd5);
		push_beat(32'd7);
		push_beat(32'd5);
		push_beat(32'd7);
		push_beat(32'd4);
		push_beat(32'd5);
		repeat (7) pop_beat();
	endtask

	task automatic test_full_stack();
		logic [31:0] pool [3];
		int k;
		for (k = 0; k < 3; k++) pool[k] = $urandom;
		repeat (DEPTH) push_beat(32'h8000_0001);
		push_beat(32'h1234_5678);
		repeat (DEPTH + 1) pop_beat();
		for (k = 0; k < DEPTH; k++) push_beat(pool[$urandom_range(0, 2)]);
		repeat (2) push_beat($urandom);
		repeat (DEPTH / 2) pop_beat();
		wait_drained();
		repeat (DEPTH / 2 + 1) pop_beat();
	endtask

	task automatic test_random_phases(input int beats);
		logic [31:0] pool [8];
		int pool_size;
		int span;
		int push_pct;
		int sent;
		int k;
		sent = 0;
		while (sent < beats) begin
			span      = $urandom_range(15, 60);
			pool_size = $urandom_range(1, 8);
			case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 50;
				default: push_pct = 25;
			endcase
			for (k = 0; k < pool_size; k++) pool[k] = $urandom;
			steady = ($urandom_range(0, 3) == 0);
			repeat (span) begin
				if ($urandom_range(0, 99) < push_pct) begin
					if ($urandom_range(0, 9) == 0) push_beat($urandom);
					else push_beat(pool[$urandom_range(0, pool_size - 1)]);
				end else begin
					pop_beat();
				end
			end
			sent += span;
			if ($urandom_range(0, 2) == 0) wait_drained();
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_pop();
		test_value_extremes();
		test_frequency_order();
		test_full_stack();
		test_random_phases(450);
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end

endmodule
